[sv/nrpe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_pkg
// Types and constants shared by the NURBS rational point evaluator.
// ----------------------------------------------------------------------------
package nrpe_pkg;

    localparam logic [1:0] MODE_WR_POINT = 2'd0;
    localparam logic [1:0] MODE_WR_KNOT  = 2'd1;
    localparam logic [1:0] MODE_EVAL     = 2'd2;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_RANGE = 3'd1;
    localparam logic [2:0] STAT_WSUM  = 3'd2;
    localparam logic [2:0] STAT_BADW  = 3'd3;
    localparam logic [2:0] STAT_EMPTY = 3'd4;

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_3D     = 2'd2;
    localparam logic [1:0] CFG_MEAS   = 2'd3;

    localparam int AFRAC     = 22;
    localparam int WFRAC     = 16;
    localparam int DIV_STEPS = 57;
    localparam int HW        = 41;

    typedef struct packed {
        logic        [1:0]  mode;
        logic        [6:0]  slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] measure_in;
        logic        [23:0] point_weight;
        logic signed [31:0] knot_value;
        logic signed [31:0] param_t;
    } t_in;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] point_measure;
        logic        [2:0]  status;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] m;
        logic        [23:0] w;
    } t_point;

    typedef enum logic [1:0] {
        RET_TRI,
        RET_MEAS,
        RET_FIN
    } t_ret;

    typedef enum logic [4:0] {
        S_IDLE,
        S_KLO,
        S_KHI,
        S_KHICHK,
        S_SCAN,
        S_SCANCHK,
        S_LD,
        S_LDX,
        S_LDY,
        S_LDZ,
        S_LDW,
        S_LDWT,
        S_TS,
        S_FA,
        S_FB,
        S_FC,
        S_DIV,
        S_FE,
        S_L0,
        S_L1,
        S_L2,
        S_FW,
        S_FW1,
        S_FD0,
        S_FD1,
        S_FD2,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

[sv/nurbs_rational_point_eval.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nurbs_rational_point_eval
// Evaluates a point on a rational B-spline curve in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A transaction writes one control point, writes one knot, or evaluates the
// curve at a parameter; each returns one result. An evaluation scans the
// knots for the span, loads its p+1 control points (degree p), runs the
// interpolation triangle and divides each coordinate by the weight; an enabled
// measure adds an interpolation, and a factor of exactly 0 or 1 skips its division.
// The evaluation time is set by one shared radix-2 divider, used for every
// interpolation factor and every final division, and by the control point and
// knot memories, each with one read port, read one entry per cycle.
// The block takes no new transaction until the current result is loaded.
// ----------------------------------------------------------------------------
module nurbs_rational_point_eval #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_index,
    input  logic [6:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  nrpe_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output nrpe_pkg::t_out  o_out
);
    import nrpe_pkg::*;

    localparam int KD  = MAX_POINTS + MAX_DEGREE + 1;
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int KAW = $clog2(KD);
    localparam int IW  = $clog2(KD + 1);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int HAW = DW + 2;
    localparam int HD  = (MAX_DEGREE + 1) * 4;
    localparam int MAW = 42;
    localparam int MBW = 25;
    localparam int PRW = MAW + MBW;

    function automatic logic signed [PRW-1:0] f_rnd(input logic signed [PRW-1:0] v,
                                                   input int sh);
        logic [PRW-1:0] mag;
        logic [PRW-1:0] r;
        mag = v[PRW-1] ? PRW'(-v) : PRW'(v);
        r   = (mag + (PRW'(1) << (sh - 1))) >> sh;
        return v[PRW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic neg, input logic [56:0] q);
        logic signed [31:0] r;
        if (!neg) begin
            r = (q > 57'd2147483647) ? 32'sh7FFFFFFF : $signed(q[31:0]);
        end else begin
            r = (q > 57'd2147483648) ? 32'sh80000000 : $signed(32'd0 - q[31:0]);
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [2:0]  r_degree;
    logic [6:0]  r_count;
    logic        r_3d;
    logic        r_meas;

    logic signed [31:0] r_t;
    logic [IW-1:0]      r_s;
    logic [IW-1:0]      r_span;
    logic [DW-1:0]      r_i;
    logic [DW-1:0]      r_lv;
    logic [1:0]         r_k;
    logic [KAW-1:0]     r_fa;
    logic [KAW-1:0]     r_fb;
    t_ret               r_ret;
    logic signed [31:0] r_ka;
    logic [22:0]        r_alpha;
    logic [23:0]        r_w;
    logic               r_neg;
    logic signed [31:0] r_m1;
    logic signed [31:0] r_res [4];
    logic [2:0]         r_status;

    logic [32:0] r_drem;
    logic [32:0] r_dden;
    logic [56:0] r_dnum;
    logic [56:0] r_dquo;
    logic [5:0]  r_dcnt;

    t_point             r_pmem [MAX_POINTS];
    t_point             r_pq;
    logic signed [31:0] r_kmem [KD];
    logic signed [31:0] r_kq;
    logic signed [HW-1:0] r_hmem [HD];
    logic signed [HW-1:0] r_ha;
    logic signed [HW-1:0] r_hb;

    logic signed [PRW-1:0] r_prod;
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;

    logic        r_out_valid;
    t_out        r_out;

    logic           in_acc;
    logic           out_free;
    logic [DW-1:0]  p_cur;
    logic [IW-1:0]  p_w;
    logic [IW-1:0]  n_cur;
    logic [IW-1:0]  base;
    logic [IW-1:0]  i2;
    logic           empty;
    logic           scan_more;
    logic [KAW-1:0] kaddr;
    logic [PAW-1:0] paddr;
    logic [HAW-1:0] ha_addr;
    logic [HAW-1:0] hb_addr;
    logic           h_we;
    logic [HAW-1:0] h_waddr;
    logic signed [HW-1:0] h_wdata;
    logic           pt_we;
    logic           kn_we;

    logic signed [32:0] fnum;
    logic signed [32:0] fden;
    logic               f_zero;
    logic               f_one;
    logic [33:0]        d_sh;
    logic               d_ge;
    logic [33:0]        d_rem;
    logic signed [PRW-1:0] rnd16;
    logic signed [PRW-1:0] lerp_h;
    logic signed [PRW-1:0] lerp_m;
    logic [HW-1:0]      hmag;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign p_cur = (int'(r_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(r_degree);
    assign n_cur = (int'(r_count) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(r_count);
    assign p_w   = IW'(p_cur);
    assign base  = r_span - p_w;
    assign i2    = ((base + IW'(1)) < n_cur) ? (base + IW'(1)) : (n_cur - IW'(1));
    assign empty = n_cur < (p_w + IW'(1));
    assign scan_more = (r_s + IW'(1)) < n_cur;

    assign pt_we = in_acc && (i_in.mode == MODE_WR_POINT) && (i_in.point_weight != 24'd0)
                   && (int'(i_in.slot) < MAX_POINTS);
    assign kn_we = in_acc && (i_in.mode == MODE_WR_KNOT) && (int'(i_in.slot) < KD);

    assign fnum   = 33'(r_t) - 33'(r_ka);
    assign fden   = 33'(r_kq) - 33'(r_ka);
    assign f_zero = (fden <= 33'sd0) || (fnum <= 33'sd0);
    assign f_one  = fnum >= fden;

    assign d_sh  = {r_drem, r_dnum[56]};
    assign d_ge  = d_sh >= {1'b0, r_dden};
    assign d_rem = d_ge ? (d_sh - {1'b0, r_dden}) : d_sh;

    assign rnd16  = f_rnd(r_prod, WFRAC);
    assign lerp_h = PRW'(r_ha) + f_rnd(r_prod, AFRAC);
    assign lerp_m = PRW'(r_m1) + f_rnd(r_prod, AFRAC);
    assign hmag   = r_ha[HW-1] ? HW'(-r_ha) : HW'(r_ha);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.mode == MODE_EVAL) ? S_KLO : S_OUT;
                end
            end
            S_KLO:     n_state = empty ? S_OUT : S_KHI;
            S_KHI:     n_state = (r_t < r_kq) ? S_OUT : S_KHICHK;
            S_KHICHK:  n_state = (r_t > r_kq) ? S_OUT : S_SCAN;
            S_SCAN:    n_state = S_SCANCHK;
            S_SCANCHK: n_state = scan_more ? S_SCAN : S_LD;
            S_LD:      n_state = S_LDX;
            S_LDX:     n_state = S_LDY;
            S_LDY:     n_state = S_LDZ;
            S_LDZ:     n_state = S_LDW;
            S_LDW:     n_state = S_LDWT;
            S_LDWT: begin
                if (r_i != p_cur) begin
                    n_state = S_LD;
                end else begin
                    n_state = (p_cur == DW'(0)) ? S_FW : S_TS;
                end
            end
            S_TS:      n_state = S_FA;
            S_FA:      n_state = S_FB;
            S_FB:      n_state = S_FC;
            S_FC: begin
                if (f_zero || f_one) begin
                    n_state = (r_ret == RET_TRI) ? S_L0 : S_M1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dcnt == 6'd1) begin
                    n_state = (r_ret == RET_FIN) ? S_FD2 : S_FE;
                end
            end
            S_FE:      n_state = (r_ret == RET_TRI) ? S_L0 : S_M1;
            S_L0:      n_state = S_L1;
            S_L1:      n_state = S_L2;
            S_L2: begin
                if (r_k != 2'd3) begin
                    n_state = S_L0;
                end else if (r_i > r_lv || r_lv < p_cur) begin
                    n_state = S_TS;
                end else begin
                    n_state = S_FW;
                end
            end
            S_FW:      n_state = S_FW1;
            S_FW1:     n_state = (r_ha <= '0) ? S_OUT : S_FD0;
            S_FD0:     n_state = S_FD1;
            S_FD1:     n_state = S_DIV;
            S_FD2: begin
                if (r_k != 2'd2) begin
                    n_state = S_FD0;
                end else begin
                    n_state = r_meas ? S_FA : S_OUT;
                end
            end
            S_M1:      n_state = S_M2;
            S_M2:      n_state = S_M3;
            S_M3:      n_state = S_M4;
            S_M4:      n_state = S_OUT;
            S_OUT:     n_state = out_free ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        kaddr   = r_fa;
        paddr   = PAW'(base + IW'(r_i));
        ha_addr = {r_i - DW'(1), r_k};
        hb_addr = {r_i, r_k};
        h_we    = 1'b0;
        h_waddr = {r_i, r_k};
        h_wdata = HW'(lerp_h);
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_KLO:     kaddr = KAW'(p_w);
            S_KHI:     kaddr = KAW'(n_cur);
            S_SCAN:    kaddr = KAW'(r_s);
            S_FB:      kaddr = r_fb;
            S_LDX: begin
                mul_a = MAW'(r_pq.x);
                mul_b = MBW'($signed({1'b0, r_pq.w}));
            end
            S_LDY: begin
                h_we    = 1'b1;
                h_waddr = {r_i, 2'd0};
                h_wdata = HW'(rnd16);
                mul_a   = MAW'(r_pq.y);
                mul_b   = MBW'($signed({1'b0, r_pq.w}));
            end
            S_LDZ: begin
                h_we    = 1'b1;
                h_waddr = {r_i, 2'd1};
                h_wdata = HW'(rnd16);
                mul_a   = MAW'(r_pq.z);
                mul_b   = MBW'($signed({1'b0, r_pq.w}));
            end
            S_LDW: begin
                h_we    = 1'b1;
                h_waddr = {r_i, 2'd2};
                h_wdata = r_3d ? HW'(rnd16) : '0;
            end
            S_LDWT: begin
                h_we    = 1'b1;
                h_waddr = {r_i, 2'd3};
                h_wdata = HW'(r_pq.w);
            end
            S_L1: begin
                mul_a = MAW'(r_hb) - MAW'(r_ha);
                mul_b = MBW'($signed({1'b0, r_alpha}));
            end
            S_L2:      h_we = 1'b1;
            S_FW, S_FW1: ha_addr = {p_cur, 2'd3};
            S_FD0, S_FD1: ha_addr = {p_cur, r_k};
            S_M1:      paddr = PAW'(base);
            S_M2:      paddr = PAW'(i2);
            S_M3: begin
                paddr = PAW'(i2);
                mul_a = MAW'(r_pq.m) - MAW'(r_m1);
                mul_b = MBW'($signed({1'b0, r_alpha}));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_degree <= 3'd2;
            r_count  <= 7'd0;
            r_3d     <= 1'b0;
            r_meas   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DEGREE: r_degree <= i_cfg_wdata[2:0];
                    CFG_COUNT:  r_count  <= i_cfg_wdata;
                    CFG_3D:     r_3d     <= i_cfg_wdata[0];
                    CFG_MEAS:   r_meas   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_t      <= i_in.param_t;
                    r_status <= STAT_OK;
                    for (int j = 0; j < 4; j++) begin
                        r_res[j] <= '0;
                    end
                    if (i_in.mode == MODE_WR_POINT && i_in.point_weight == 24'd0) begin
                        r_status <= STAT_BADW;
                    end
                end
            end
            S_KLO: begin
                if (empty) begin
                    r_status <= STAT_EMPTY;
                end
            end
            S_KHI: begin
                if (r_t < r_kq) begin
                    r_status <= STAT_RANGE;
                end
            end
            S_KHICHK: begin
                if (r_t > r_kq) begin
                    r_status <= STAT_RANGE;
                end
                r_s    <= p_w;
                r_span <= p_w;
                r_i    <= '0;
            end
            S_SCANCHK: begin
                if (r_kq <= r_t) begin
                    r_span <= r_s;
                end
                r_s <= r_s + IW'(1);
            end
            S_LDWT: begin
                if (r_i != p_cur) begin
                    r_i <= r_i + DW'(1);
                end else begin
                    r_i  <= p_cur;
                    r_lv <= DW'(1);
                end
            end
            S_TS: begin
                r_fa  <= KAW'(base + IW'(r_i));
                r_fb  <= KAW'(base + IW'(r_i) + p_w + IW'(1) - IW'(r_lv));
                r_ret <= RET_TRI;
                r_k   <= 2'd0;
            end
            S_FB: r_ka <= r_kq;
            S_FC: begin
                r_alpha <= f_zero ? 23'd0 : 23'd4194304;
                r_dden  <= fden[32:0];
                r_dnum  <= (57'(fnum[32:0]) << AFRAC) + 57'(fden[32:1]);
                r_drem  <= '0;
                r_dcnt  <= 6'(DIV_STEPS);
            end
            S_DIV: begin
                r_drem <= d_rem[32:0];
                r_dnum <= {r_dnum[55:0], 1'b0};
                r_dquo <= {r_dquo[55:0], d_ge};
                r_dcnt <= r_dcnt - 6'd1;
            end
            S_FE: r_alpha <= r_dquo[22:0];
            S_L2: begin
                if (r_k != 2'd3) begin
                    r_k <= r_k + 2'd1;
                end else if (r_i > r_lv) begin
                    r_i <= r_i - DW'(1);
                end else if (r_lv < p_cur) begin
                    r_lv <= r_lv + DW'(1);
                    r_i  <= p_cur;
                end
            end
            S_FW1: begin
                if (r_ha <= '0) begin
                    r_status <= STAT_WSUM;
                end
                r_w <= r_ha[23:0];
                r_k <= 2'd0;
            end
            S_FD1: begin
                r_neg  <= r_ha[HW-1];
                r_dden <= 33'(r_w);
                r_dnum <= (57'(hmag) << WFRAC) + 57'(r_w[23:1]);
                r_drem <= '0;
                r_dcnt <= 6'(DIV_STEPS);
                r_ret  <= RET_FIN;
            end
            S_FD2: begin
                r_res[r_k] <= f_sat(r_neg, r_dquo);
                r_k        <= r_k + 2'd1;
                r_fa       <= KAW'(r_span);
                r_fb       <= KAW'(r_span + IW'(1));
                r_ret      <= RET_MEAS;
            end
            S_M2: r_m1 <= r_pq.m;
            S_M4: begin
                r_res[3] <= r_meas ? 32'(lerp_m) : '0;
                if (!r_3d) begin
                    r_res[2] <= '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pmem[PAW'(i_in.slot)] <= '{x: i_in.coord_x, y: i_in.coord_y, z: i_in.coord_z,
                                          m: i_in.measure_in, w: i_in.point_weight};
        end
        r_pq <= r_pmem[paddr];
    end

    always_ff @(posedge i_clk) begin
        if (kn_we) begin
            r_kmem[KAW'(i_in.slot)] <= i_in.knot_value;
        end
        r_kq <= r_kmem[kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hmem[h_waddr] <= h_wdata;
        end
        r_ha <= r_hmem[ha_addr];
        r_hb <= r_hmem[hb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out.point_x       <= r_res[0];
            r_out.point_y       <= r_res[1];
            r_out.point_z       <= r_res[2];
            r_out.point_measure <= r_res[3];
            r_out.status        <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
